[hw/rtl/ed_pkg.sv]
// Shared widths and command codes for the edit distance engine.
package ed_pkg;

  localparam int CMD_W  = 2;
  localparam int SYM_W  = 8;
  localparam int DIST_W = 7;

  // Largest distance the result field can carry; larger values saturate.
  localparam logic [DIST_W-1:0] DIST_MAX = 7'd127;

  // Request commands
  localparam logic [CMD_W-1:0] CMD_LOAD_FIRST  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_SECOND = 2'd1;
  localparam logic [CMD_W-1:0] CMD_COMPUTE     = 2'd2;

endpackage

[hw/rtl/ed_in_if.sv]
// Request channel of the edit distance engine: command and symbol.
interface ed_in_if;
  import ed_pkg::*;

  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  logic [SYM_W-1:0] symbol;

  modport source (output valid, output cmd, output symbol, input ready);
  modport sink   (input valid, input cmd, input symbol, output ready);

endinterface

[hw/rtl/ed_out_if.sv]
// Result channel of the edit distance engine: distance and overflow flag.
interface ed_out_if;
  import ed_pkg::*;

  logic              valid;
  logic              ready;
  logic [DIST_W-1:0] distance;
  logic              overflow;

  modport source (output valid, output distance, output overflow, input ready);
  modport sink   (input valid, input distance, input overflow, output ready);

endinterface

[hw/rtl/ed_cell.sv]
// Score unit for one matrix cell: minimum of insert, delete and substitute costs.
module ed_cell #(
  parameter int SCORE_W = 7
) (
  input  logic [SCORE_W-1:0] up,
  input  logic [SCORE_W-1:0] left,
  input  logic [SCORE_W-1:0] diag,
  input  logic               mismatch,
  output logic [SCORE_W-1:0] best
);

  // One extra bit so the +1 candidates never wrap
  localparam int SW = SCORE_W + 1;

  logic [SW-1:0] up_cost;
  logic [SW-1:0] left_cost;
  logic [SW-1:0] sub_cost;
  logic [SW-1:0] min_ul;
  logic [SW-1:0] min_all;

  assign up_cost   = SW'(up) + SW'(1);
  assign left_cost = SW'(left) + SW'(1);
  assign sub_cost  = SW'(diag) + SW'(mismatch);

  assign min_ul  = (left_cost < up_cost) ? left_cost : up_cost;
  assign min_all = (sub_cost < min_ul) ? sub_cost : min_ul;

  // A cell score never exceeds the longer prefix, so it fits the score width
  assign best = min_all[SCORE_W-1:0];

endmodule

[hw/rtl/edit_distance_engine.sv]
// Top level of the edit distance engine: string buffers, row memory and sweep sequencer.
//
// Load requests (cmd 0 and 1) append one byte to the first or second string; a byte
// past MAX_LEN is dropped and flags overflow. A compute request (cmd 2) holds the
// request channel low from acceptance until its result is issued; with an empty
// string the result is the other length. Otherwise the row memory is first seeded,
// then for each matrix cell the row memory and the second string are read, and the
// cell is then scored in the single cell unit and written back. The
// result sits in an output register, so loads for the next pair are accepted while it
// waits to be taken; a compute that finishes while the previous result still waits
// stays in its done state, request channel low, until that result is taken.
// Cmd 3 is ignored. Distances above 127 saturate to 127.
module edit_distance_engine #(
  parameter int MAX_LEN = 64
) (
  input logic     clk,
  input logic     rst_n,
  ed_in_if.sink   in_ch,
  ed_out_if.source out_ch
);
  import ed_pkg::*;

  localparam int LW = $clog2(MAX_LEN + 1);
  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int XW = (LW > DIST_W) ? LW : DIST_W;
  localparam logic [LW-1:0] MAX_L = LW'(MAX_LEN);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_INIT = 6'b000010,
    S_ROW  = 6'b000100,
    S_RD   = 6'b001000,
    S_CMP  = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [LW-1:0] len_a_r, len_a_nxt;
  logic [LW-1:0] len_b_r, len_b_nxt;
  logic          ovf_r, ovf_nxt;
  logic [LW-1:0] ri_r, ri_nxt;
  logic [LW-1:0] cj_r, cj_nxt;
  logic [LW-1:0] left_r, left_nxt;
  logic [LW-1:0] diag_r, diag_nxt;
  logic [LW-1:0] res_r, res_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [DIST_W-1:0] out_dist_r;
  logic              out_ovf_r;

  // String buffers and working row (row entry k holds score of column k+1)
  logic [SYM_W-1:0] mem_a   [MAX_LEN];
  logic [SYM_W-1:0] mem_b   [MAX_LEN];
  logic [LW-1:0]    mem_row [MAX_LEN];

  logic [SYM_W-1:0] a_rd_r;
  logic [SYM_W-1:0] b_rd_r;
  logic [LW-1:0]    row_rd_r;

  logic          in_acc;
  logic          wr_a;
  logic          wr_b;
  logic          out_free;
  logic          load_out;
  logic          row_we;
  logic [LW-1:0] row_wdata;
  logic          m_last;
  logic          n_last;
  logic [LW-1:0] best;
  logic [XW-1:0] res_x;
  logic [DIST_W-1:0] dist_sat;

  // Handshake
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign load_out    = (state_r == S_DONE) && out_free;

  assign wr_a = in_acc && (in_ch.cmd == CMD_LOAD_FIRST) && (len_a_r != MAX_L);
  assign wr_b = in_acc && (in_ch.cmd == CMD_LOAD_SECOND) && (len_b_r != MAX_L);

  // Sweep position
  assign m_last = (cj_r == len_b_r - LW'(1));
  assign n_last = (ri_r == len_a_r - LW'(1));

  // Row memory write: seed with column index, then cell scores
  assign row_we    = (state_r == S_INIT) || (state_r == S_CMP);
  assign row_wdata = (state_r == S_INIT) ? (cj_r + LW'(1)) : best;

  // Shared cell unit
  ed_cell #(
    .SCORE_W (LW)
  ) u_cell (
    .up       (row_rd_r),
    .left     (left_r),
    .diag     (diag_r),
    .mismatch (a_rd_r != b_rd_r),
    .best     (best)
  );

  // Result saturation
  assign res_x    = XW'(res_r);
  assign dist_sat = (res_x > XW'(DIST_MAX)) ? DIST_MAX : res_x[DIST_W-1:0];

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    len_a_nxt     = len_a_r;
    len_b_nxt     = len_b_r;
    ovf_nxt       = ovf_r;
    ri_nxt        = ri_r;
    cj_nxt        = cj_r;
    left_nxt      = left_r;
    diag_nxt      = diag_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_ch.cmd)
            CMD_LOAD_FIRST: begin
              if (len_a_r != MAX_L) len_a_nxt = len_a_r + LW'(1);
              else                  ovf_nxt   = 1'b1;
            end
            CMD_LOAD_SECOND: begin
              if (len_b_r != MAX_L) len_b_nxt = len_b_r + LW'(1);
              else                  ovf_nxt   = 1'b1;
            end
            CMD_COMPUTE: begin
              // Empty string: distance is the other length
              if (len_a_r == '0) begin
                res_nxt   = len_b_r;
                state_nxt = S_DONE;
              end else if (len_b_r == '0) begin
                res_nxt   = len_a_r;
                state_nxt = S_DONE;
              end else begin
                cj_nxt    = '0;
                state_nxt = S_INIT;
              end
            end
            default: ;
          endcase
        end
      end
      S_INIT: begin
        if (m_last) begin
          cj_nxt    = '0;
          ri_nxt    = '0;
          state_nxt = S_ROW;
        end else begin
          cj_nxt = cj_r + LW'(1);
        end
      end
      S_ROW: begin
        // Column zero of row ri+1 is ri+1; the old one is ri
        left_nxt  = ri_r + LW'(1);
        diag_nxt  = ri_r;
        state_nxt = S_CMP;
      end
      S_RD: begin
        state_nxt = S_CMP;
      end
      S_CMP: begin
        diag_nxt = row_rd_r;
        left_nxt = best;
        if (m_last) begin
          if (n_last) begin
            res_nxt   = best;
            state_nxt = S_DONE;
          end else begin
            ri_nxt    = ri_r + LW'(1);
            cj_nxt    = '0;
            state_nxt = S_ROW;
          end
        end else begin
          cj_nxt    = cj_r + LW'(1);
          state_nxt = S_RD;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          len_a_nxt     = '0;
          len_b_nxt     = '0;
          ovf_nxt       = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_a_r     <= '0;
      len_b_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_a_r     <= len_a_nxt;
      len_b_r     <= len_b_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    ri_r   <= ri_nxt;
    cj_r   <= cj_nxt;
    left_r <= left_nxt;
    diag_r <= diag_nxt;
    res_r  <= res_nxt;
    if (load_out) begin
      out_dist_r <= dist_sat;
      out_ovf_r  <= ovf_r;
    end
  end

  // Memories: one write and one registered read each
  always_ff @(posedge clk) begin
    if (wr_a) mem_a[len_a_r[AW-1:0]] <= in_ch.symbol;
    a_rd_r <= mem_a[ri_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (wr_b) mem_b[len_b_r[AW-1:0]] <= in_ch.symbol;
    b_rd_r <= mem_b[cj_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (row_we) mem_row[cj_r[AW-1:0]] <= row_wdata;
    row_rd_r <= mem_row[cj_r[AW-1:0]];
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.distance = out_dist_r;
  assign out_ch.overflow = out_ovf_r;

  // Checks
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (len_a_r <= MAX_L) && (len_b_r <= MAX_L))
    else $error("string length above MAX_LEN");

  a_compute_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_ch.cmd == CMD_COMPUTE)) |=> !in_ch.ready)
    else $error("request accepted right after compute");

  a_sweep_range: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_RD) || (state_r == S_CMP)) |-> ((cj_r < len_b_r) && (ri_r < len_a_r)))
    else $error("sweep index outside loaded strings");

  a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> (out_valid_r && (len_a_r == '0) && (len_b_r == '0) && !ovf_r))
    else $error("result issue did not clear the pair");

endmodule
